// File: src/mqfb_pkg.sv
// Shared types and constants for the bounded multi-queue block.
// Used by the front, back and top-level modules; depends on nothing else.
package mqfb_pkg;

   localparam int NUM_QUEUES  = 32;
   localparam int QUEUE_DEPTH = 8;
   localparam int STORE_SIZE  = NUM_QUEUES * QUEUE_DEPTH;

   // fixed field widths of the request and response beats
   localparam int QINDEX_W = 5;
   localparam int ID_W     = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   localparam int QSEL_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int ADDR_W  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int ENTRY_W = ID_W + 1;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_TAKE = 1'b1
   } opcode_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

   typedef struct packed {
      logic              is_take;
      logic              bad;
      logic [QSEL_W-1:0] qsel;
      logic [ID_W-1:0]   id;
      logic              urgent;
   } cmd_type;

endpackage

// File: src/mqfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module mqfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/mqfb_front.sv
// Request front end: checks the queue index, decodes the opcode and
// buffers commands in a short queue for the back end. Uses mqfb_pkg.
module mqfb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_opcode,
   input  logic [mqfb_pkg::QINDEX_W-1:0] req_queue_index,
   input  logic [mqfb_pkg::ID_W-1:0]     req_entry_id,
   input  logic                          req_urgent,
   output logic                          cmd_valid,
   output mqfb_pkg::cmd_type             cmd,
   input  logic                          cmd_pop
);
   import mqfb_pkg::*;

   cmd_type                 slot_ff [CMDQ_DEPTH];
   cmd_type                 new_cmd;
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   fill_ff, fill_in;
   logic                    accept;
   logic                    drain;

   // classify the incoming beat
   always_comb begin
      new_cmd.is_take = (opcode_type'(req_opcode) == OP_TAKE);
      new_cmd.bad     = ({1'b0, req_queue_index} >= (QINDEX_W + 1)'(NUM_QUEUES));
      new_cmd.qsel    = req_queue_index[QSEL_W-1:0];
      new_cmd.id      = req_entry_id;
      new_cmd.urgent  = req_urgent;
   end

   assign req_full  = (fill_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign accept    = req_push && !req_full;
   assign drain     = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (drain) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !drain) begin
         fill_in = fill_ff + 1'b1;
      end else if (drain && !accept) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// File: src/mqfb_back.sv
// Back end: keeps head and count per queue, runs adds and takes against
// the entry RAM and holds the response register. Uses mqfb_pkg, mqfb_ram.
module mqfb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  mqfb_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [mqfb_pkg::STATUS_W-1:0] rsp_status_code,
   output logic [mqfb_pkg::ID_W-1:0]     rsp_taken_id,
   output logic                          rsp_taken_urgent,
   output logic [mqfb_pkg::COUNT_W-1:0]  rsp_count_after
);
   import mqfb_pkg::*;

   back_state_type      state_ff, state_in;
   logic [SLOT_W-1:0]   head_ff [NUM_QUEUES];
   logic [COUNT_W-1:0]  cnt_ff  [NUM_QUEUES];
   logic [SLOT_W-1:0]   head_in;
   logic [COUNT_W-1:0]  cnt_in;
   logic                upd;

   logic [SLOT_W-1:0]   head_rd, head_dec, head_inc, tail, slot;
   logic [COUNT_W-1:0]  cnt_rd;
   logic [COUNT_W:0]    tail_sum;
   logic                q_full, q_empty;
   logic                can_issue;

   logic [ADDR_W-1:0]   ram_addr;
   logic                ram_we, ram_re;
   logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

   logic [COUNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                load;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_urg_ff, rsp_urg_in;
   logic [COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   assign head_rd  = head_ff[cmd.qsel];
   assign cnt_rd   = cnt_ff[cmd.qsel];
   assign q_full   = (cnt_rd >= COUNT_W'(QUEUE_DEPTH));
   assign q_empty  = (cnt_rd == '0);
   assign head_dec = (head_rd == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : head_rd - 1'b1;
   assign head_inc = (head_rd == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_rd + 1'b1;
   assign tail_sum = (COUNT_W + 1)'(head_rd) + (COUNT_W + 1)'(cnt_rd);
   // wrap the back slot with one compare and subtract
   assign tail     = (tail_sum >= (COUNT_W + 1)'(QUEUE_DEPTH))
                     ? SLOT_W'(tail_sum - (COUNT_W + 1)'(QUEUE_DEPTH))
                     : SLOT_W'(tail_sum);
   assign ram_addr  = ADDR_W'(cmd.qsel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
   assign ram_wdata = {cmd.id, cmd.urgent};

   // a new command may start while the held response leaves this cycle
   assign can_issue = (state_ff == BK_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_pop);
   assign cmd_pop   = can_issue;

   always_comb begin
      state_in      = state_ff;
      slot          = head_rd;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      upd           = 1'b0;
      head_in       = head_rd;
      cnt_in        = cnt_rd;
      pend_cnt_in   = pend_cnt_ff;
      load          = 1'b0;
      rsp_status_in = ST_OK;
      rsp_id_in     = '0;
      rsp_urg_in    = 1'b0;
      rsp_cnt_in    = '0;
      case (state_ff)
         BK_IDLE: begin
            if (can_issue) begin
               if (cmd.bad) begin
                  load          = 1'b1;
                  rsp_status_in = ST_BAD_INDEX;
               end else if (!cmd.is_take) begin
                  load = 1'b1;
                  if (q_full) begin
                     rsp_status_in = ST_FULL;
                     rsp_cnt_in    = cnt_rd;
                  end else begin
                     // urgent goes ahead of the current head, regular after the tail
                     slot       = cmd.urgent ? head_dec : tail;
                     head_in    = cmd.urgent ? head_dec : head_rd;
                     cnt_in     = cnt_rd + 1'b1;
                     ram_we     = 1'b1;
                     upd        = 1'b1;
                     rsp_cnt_in = cnt_rd + 1'b1;
                  end
               end else if (q_empty) begin
                  load          = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  slot        = head_rd;
                  head_in     = head_inc;
                  cnt_in      = cnt_rd - 1'b1;
                  ram_re      = 1'b1;
                  upd         = 1'b1;
                  pend_cnt_in = cnt_rd - 1'b1;
                  state_in    = BK_READ;
               end
            end
         end
         BK_READ: begin
            load       = 1'b1;
            rsp_id_in  = ram_rdata[ENTRY_W-1:1];
            rsp_urg_in = ram_rdata[0];
            rsp_cnt_in = pend_cnt_ff;
            state_in   = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd) begin
            head_ff[cmd.qsel] <= head_in;
            cnt_ff[cmd.qsel]  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_cnt_ff <= pend_cnt_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_urg_ff    <= rsp_urg_in;
         rsp_cnt_ff    <= rsp_cnt_in;
      end
   end

   mqfb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_status_code  = rsp_status_ff;
   assign rsp_taken_id     = rsp_id_ff;
   assign rsp_taken_urgent = rsp_urg_ff;
   assign rsp_count_after  = rsp_cnt_ff;

   // the response slot is free while a take waits for its read data
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_READ) |-> !rsp_valid_ff)
      else $error("response register busy during take read");

   a_take_reads: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> (state_ff == BK_READ))
      else $error("take read without read state");

   a_one_ram_op: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("entry RAM written and read in one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && !cmd.bad) |-> (cnt_rd <= COUNT_W'(QUEUE_DEPTH)))
      else $error("queue count above depth");

   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

endmodule

// File: src/multi_queue_front_back_insert.sv
// Bounded multi-queue: NUM_QUEUES queues of up to QUEUE_DEPTH entries each.
// An add puts a regular entry at the back of the named queue and an urgent
// entry at the very front; a take removes and returns the front entry. Every
// request beat yields exactly one response beat with a status code and the
// count left in the named queue. Requests enter a two-deep command queue at
// up to one beat per cycle while it is not full. The back end finishes an
// add, a bad index, a full add or an empty take straight from its idle
// state, and a successful take through a further read state because the
// entry RAM read is registered; so adds sustain one beat per cycle while
// responses are popped, and a take holds off the next command until done.
// Head and count per queue are flip-flops cleared by reset; the entry RAM
// needs no clearing since only written slots are ever read.
module multi_queue_front_back_insert (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_opcode,
   input  logic [mqfb_pkg::QINDEX_W-1:0] req_queue_index,
   input  logic [mqfb_pkg::ID_W-1:0]     req_entry_id,
   input  logic                          req_urgent,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [mqfb_pkg::STATUS_W-1:0] rsp_status_code,
   output logic [mqfb_pkg::ID_W-1:0]     rsp_taken_id,
   output logic                          rsp_taken_urgent,
   output logic [mqfb_pkg::COUNT_W-1:0]  rsp_count_after
);
   import mqfb_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   mqfb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_queue_index (req_queue_index),
      .req_entry_id    (req_entry_id),
      .req_urgent      (req_urgent),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   mqfb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_status_code  (rsp_status_code),
      .rsp_taken_id     (rsp_taken_id),
      .rsp_taken_urgent (rsp_taken_urgent),
      .rsp_count_after  (rsp_count_after)
   );

endmodule
